### design/ddra_pkg.sv
package ddra_pkg;

   localparam int MAX_SLOTS      = 4096;
   localparam int MAX_RING_BYTES = 16777216;
   localparam int SLOT_W         = $clog2(MAX_SLOTS);
   localparam int SLOTS_W        = SLOT_W + 1;
   localparam int PTR_W          = $clog2(MAX_RING_BYTES);
   localparam int LEN_W          = PTR_W + 1;
   localparam int NEED_W         = LEN_W + 1;
   localparam int SUM_W          = LEN_W + 2;
   localparam int CNT_W          = $clog2(SUM_W);
   localparam int CSR_DATA_W     = 25;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PROBE = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NO_SPACE = 2'd1,
      STS_TOO_BIG  = 2'd2,
      STS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      CSR_SLOT_COUNT = 1'b0,
      CSR_RING_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_MOD,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [PTR_W-1:0] offset;
      logic [LEN_W-1:0] payload_len;
      logic [LEN_W-1:0] extra_len;
   } slot_entry_type;

endpackage

### design/descriptor_and_data_ring_allocator.sv
// Descriptor ring with a contiguous byte data ring.
// Request channel (req_*): one command per transfer: push reserves a slot and a
// contiguous region of payload_len + extra_len bytes (wrapping to offset 0 and
// skipping the tail when the region would run past the end), probe answers the
// same without committing, pop returns and frees the oldest descriptor.
// Response channel (rsp_*): exactly one transfer per request, in order.
// Configuration port (csr_*): index 0 slot_count, index 1 ring_bytes; write
// only while no request is in flight.
// Sequence: a push, probe, empty pop or zero-length pop passes through the
// execute and done states before its result enters the response register.
// A push whose new fill pointer lies beyond the ring size and a pop with data
// also pass through the modulo state: the new pointer is reduced modulo
// ring_bytes by a bit-serial unit, one bit per cycle over 27 bits. Descriptors
// live in one 4096-entry memory with a registered read, fetched at the read
// slot before the pop executes. One request is worked at a time; the next
// is taken the cycle after the previous result enters the response register.
// When the receiver stalls, the response is held and the block stops after
// finishing one more request.
// Reset clears the slot and byte pointers and restores the register defaults;
// descriptor memory is not cleared.
module descriptor_and_data_ring_allocator
   import ddra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   input  logic [LEN_W-1:0]      req_payload_len,
   input  logic [LEN_W-1:0]      req_extra_len,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [SLOT_W-1:0]     rsp_slot,
   output logic [PTR_W-1:0]      rsp_payload_offset,
   output logic [LEN_W-1:0]      rsp_extra_offset,
   output logic [LEN_W-1:0]      rsp_popped_payload_len,
   output logic [LEN_W-1:0]      rsp_popped_extra_len,
   output logic                  rsp_ring_nonempty,
   output logic                  rsp_slot_free,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s,
                                                    input logic [SLOTS_W-1:0] n);
      logic [SLOTS_W-1:0] nxt;
      nxt = {1'b0, s} + SLOTS_W'(1);
      return (nxt >= n) ? '0 : nxt[SLOT_W-1:0];
   endfunction

   fsm_type              state_ff, state_in;
   command_type          cmd_ff, cmd_in;
   logic [LEN_W-1:0]     plen_ff, plen_in;
   logic [LEN_W-1:0]     elen_ff, elen_in;
   logic [SLOT_W-1:0]    ws_ff, ws_in;
   logic [SLOT_W-1:0]    rs_ff, rs_in;
   logic [PTR_W-1:0]     fill_ff, fill_in;
   logic [PTR_W-1:0]     free_ff, free_in;
   logic [SLOTS_W-1:0]   slot_count_ff, slot_count_in;
   logic [LEN_W-1:0]     ring_bytes_ff, ring_bytes_in;

   status_type           res_status_ff, res_status_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [PTR_W-1:0]     res_poff_ff, res_poff_in;
   logic [LEN_W-1:0]     res_eoff_ff, res_eoff_in;
   logic [LEN_W-1:0]     res_ppl_ff, res_ppl_in;
   logic [LEN_W-1:0]     res_pel_ff, res_pel_in;

   logic [SUM_W-1:0]     mod_val_ff, mod_val_in;
   logic [LEN_W-1:0]     mod_rem_ff, mod_rem_in;
   logic [CNT_W-1:0]     mod_cnt_ff, mod_cnt_in;
   logic                 mod_to_free_ff, mod_to_free_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [PTR_W-1:0]     rsp_poff_ff, rsp_poff_in;
   logic [LEN_W-1:0]     rsp_eoff_ff, rsp_eoff_in;
   logic [LEN_W-1:0]     rsp_ppl_ff, rsp_ppl_in;
   logic [LEN_W-1:0]     rsp_pel_ff, rsp_pel_in;
   logic                 rsp_nonempty_ff, rsp_nonempty_in;
   logic                 rsp_free_ff, rsp_free_in;

   slot_entry_type       mem [MAX_SLOTS];
   slot_entry_type       rd_ff;
   slot_entry_type       wr_entry;
   logic                 mem_we;

   logic [SLOTS_W-1:0]   eff_slots;
   logic [LEN_W-1:0]     eff_bytes;
   logic [NEED_W-1:0]    size_n;
   logic [NEED_W-1:0]    need;
   logic [PTR_W-1:0]     used;
   status_type           fs_status;
   logic [PTR_W-1:0]     fs_off;
   logic [LEN_W-1:0]     fs_nf;
   logic [NEED_W-1:0]    mod_t;
   logic [NEED_W-1:0]    mod_r;
   logic                 accept;
   logic                 load_rsp;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == FSM_IDLE);
   assign load_rsp  = (state_ff == FSM_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      eff_slots = slot_count_ff;
      if (slot_count_ff < SLOTS_W'(2)) begin
         eff_slots = SLOTS_W'(2);
      end else if (slot_count_ff > SLOTS_W'(MAX_SLOTS)) begin
         eff_slots = SLOTS_W'(MAX_SLOTS);
      end
      eff_bytes = ring_bytes_ff;
      if (ring_bytes_ff == '0) begin
         eff_bytes = LEN_W'(1);
      end else if (ring_bytes_ff > LEN_W'(MAX_RING_BYTES)) begin
         eff_bytes = LEN_W'(MAX_RING_BYTES);
      end
      size_n = {1'b0, eff_bytes};
   end

   always_comb begin
      need      = {1'b0, plen_ff} + {1'b0, elen_ff};
      used      = fill_ff - free_ff;
      fs_status = STS_OK;
      fs_off    = '0;
      fs_nf     = '0;
      if (slot_after(ws_ff, eff_slots) == rs_ff) begin
         fs_status = STS_NO_SPACE;
      end else if (need > size_n) begin
         fs_status = STS_TOO_BIG;
      end else if (fill_ff >= free_ff) begin
         if ({1'b0, used} >= eff_bytes) begin
            fs_status = STS_NO_SPACE;
         end else if (need > size_n - NEED_W'(used) - NEED_W'(1)) begin
            fs_status = STS_NO_SPACE;
         end else if (NEED_W'(fill_ff) + need > size_n) begin
            if (NEED_W'(free_ff) <= need) begin
               fs_status = STS_NO_SPACE;
            end else begin
               fs_off = '0;
               fs_nf  = need[LEN_W-1:0];
            end
         end else begin
            fs_off = fill_ff;
            fs_nf  = LEN_W'(fill_ff) + need[LEN_W-1:0];
         end
      end else begin
         if (need > NEED_W'(free_ff - fill_ff - PTR_W'(1))) begin
            fs_status = STS_NO_SPACE;
         end else begin
            fs_off = fill_ff;
            fs_nf  = LEN_W'(fill_ff) + need[LEN_W-1:0];
         end
      end
   end

   always_comb begin
      mod_t = {mod_rem_ff, mod_val_ff[SUM_W-1]};
      mod_r = (mod_t >= size_n) ? (mod_t - size_n) : mod_t;
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      plen_in         = plen_ff;
      elen_in         = elen_ff;
      ws_in           = ws_ff;
      rs_in           = rs_ff;
      fill_in         = fill_ff;
      free_in         = free_ff;
      slot_count_in   = slot_count_ff;
      ring_bytes_in   = ring_bytes_ff;
      res_status_in   = res_status_ff;
      res_slot_in     = res_slot_ff;
      res_poff_in     = res_poff_ff;
      res_eoff_in     = res_eoff_ff;
      res_ppl_in      = res_ppl_ff;
      res_pel_in      = res_pel_ff;
      mod_val_in      = mod_val_ff;
      mod_rem_in      = mod_rem_ff;
      mod_cnt_in      = mod_cnt_ff;
      mod_to_free_in  = mod_to_free_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_poff_in     = rsp_poff_ff;
      rsp_eoff_in     = rsp_eoff_ff;
      rsp_ppl_in      = rsp_ppl_ff;
      rsp_pel_in      = rsp_pel_ff;
      rsp_nonempty_in = rsp_nonempty_ff;
      rsp_free_in     = rsp_free_ff;
      mem_we          = 1'b0;
      wr_entry        = '{offset: fs_off, payload_len: plen_ff, extra_len: elen_ff};

      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_SLOT_COUNT: slot_count_in = csr_wdata[SLOTS_W-1:0];
            CSR_RING_BYTES: ring_bytes_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               cmd_in   = command_type'(req_command);
               plen_in  = req_payload_len;
               elen_in  = req_extra_len;
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            res_status_in  = STS_OK;
            res_slot_in    = '0;
            res_poff_in    = '0;
            res_eoff_in    = '0;
            res_ppl_in     = '0;
            res_pel_in     = '0;
            mod_rem_in     = '0;
            mod_cnt_in     = CNT_W'(SUM_W - 1);
            mod_to_free_in = 1'b0;
            state_in       = FSM_DONE;
            case (cmd_ff) inside
               CMD_PUSH, CMD_PROBE: begin
                  res_status_in = fs_status;
                  if (fs_status == STS_OK) begin
                     res_slot_in = ws_ff;
                     res_poff_in = fs_off;
                     res_eoff_in = LEN_W'(fs_off) + plen_ff;
                     if (cmd_ff == CMD_PUSH) begin
                        mem_we = 1'b1;
                        ws_in  = slot_after(ws_ff, eff_slots);
                        if (fs_nf < eff_bytes) begin
                           fill_in = fs_nf[PTR_W-1:0];
                        end else if (fs_nf == eff_bytes) begin
                           fill_in = '0;
                        end else begin
                           mod_val_in = SUM_W'(fs_nf);
                           state_in   = FSM_MOD;
                        end
                     end
                  end
               end
               CMD_POP: begin
                  if (ws_ff == rs_ff) begin
                     res_status_in = STS_EMPTY;
                  end else begin
                     res_slot_in = rs_ff;
                     res_poff_in = rd_ff.offset;
                     res_eoff_in = LEN_W'(rd_ff.offset) + rd_ff.payload_len;
                     res_ppl_in  = rd_ff.payload_len;
                     res_pel_in  = rd_ff.extra_len;
                     rs_in       = slot_after(rs_ff, eff_slots);
                     if ((rd_ff.payload_len | rd_ff.extra_len) != '0) begin
                        mod_val_in     = SUM_W'(rd_ff.offset) + SUM_W'(rd_ff.payload_len)
                                         + SUM_W'(rd_ff.extra_len);
                        mod_to_free_in = 1'b1;
                        state_in       = FSM_MOD;
                     end
                  end
               end
               default: ;
            endcase
         end
         FSM_MOD: begin
            mod_rem_in = mod_r[LEN_W-1:0];
            mod_val_in = {mod_val_ff[SUM_W-2:0], 1'b0};
            mod_cnt_in = mod_cnt_ff - CNT_W'(1);
            if (mod_cnt_ff == '0) begin
               if (mod_to_free_ff) begin
                  free_in = mod_r[PTR_W-1:0];
               end else begin
                  fill_in = mod_r[PTR_W-1:0];
               end
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (load_rsp) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_slot_in     = res_slot_ff;
               rsp_poff_in     = res_poff_ff;
               rsp_eoff_in     = res_eoff_ff;
               rsp_ppl_in      = res_ppl_ff;
               rsp_pel_in      = res_pel_ff;
               rsp_nonempty_in = (ws_ff != rs_ff);
               rsp_free_in     = (slot_after(ws_ff, eff_slots) != rs_ff);
               state_in        = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         ws_ff         <= '0;
         rs_ff         <= '0;
         fill_ff       <= '0;
         free_ff       <= '0;
         slot_count_ff <= SLOTS_W'(MAX_SLOTS);
         ring_bytes_ff <= LEN_W'(MAX_RING_BYTES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ws_ff         <= ws_in;
         rs_ff         <= rs_in;
         fill_ff       <= fill_in;
         free_ff       <= free_in;
         slot_count_ff <= slot_count_in;
         ring_bytes_ff <= ring_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      plen_ff         <= plen_in;
      elen_ff         <= elen_in;
      res_status_ff   <= res_status_in;
      res_slot_ff     <= res_slot_in;
      res_poff_ff     <= res_poff_in;
      res_eoff_ff     <= res_eoff_in;
      res_ppl_ff      <= res_ppl_in;
      res_pel_ff      <= res_pel_in;
      mod_val_ff      <= mod_val_in;
      mod_rem_ff      <= mod_rem_in;
      mod_cnt_ff      <= mod_cnt_in;
      mod_to_free_ff  <= mod_to_free_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_poff_ff     <= rsp_poff_in;
      rsp_eoff_ff     <= rsp_eoff_in;
      rsp_ppl_ff      <= rsp_ppl_in;
      rsp_pel_ff      <= rsp_pel_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
      rsp_free_ff     <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ws_ff] <= wr_entry;
      end
      rd_ff <= mem[rs_ff];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_slot               = rsp_slot_ff;
   assign rsp_payload_offset     = rsp_poff_ff;
   assign rsp_extra_offset       = rsp_eoff_ff;
   assign rsp_popped_payload_len = rsp_ppl_ff;
   assign rsp_popped_extra_len   = rsp_pel_ff;
   assign rsp_ring_nonempty      = rsp_nonempty_ff;
   assign rsp_slot_free          = rsp_free_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == FSM_EXEC)
      else $error("accepted request did not enter execute");

   a_mem_write_push: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == FSM_EXEC) && (cmd_ff == CMD_PUSH))
      else $error("descriptor write outside a push");

   a_mod_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_MOD |-> mod_rem_ff < eff_bytes)
      else $error("modulo remainder out of range");

   a_idle_pointers: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_IDLE |=> $stable(fill_ff) && $stable(free_ff) && $stable(ws_ff))
      else $error("pointers moved while idle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STS_OK)
      |-> (rsp_slot_ff == '0) && (rsp_poff_ff == '0) && (rsp_eoff_ff == '0))
      else $error("failed response carries an allocation");

endmodule
